// ===== rtl/dtn_pkg.sv =====
// shared types and constants for the decimal text to number core
// character codes, saturation limit and result word layout; no dependencies
package dtn_pkg;

    localparam int CHAR_W  = 8;
    localparam int MANT_W  = 64;
    localparam int SCALE_W = 5;
    localparam int DIGIT_W = 4;

    // result word: mantissa then scale, zero padded to whole bytes
    localparam int TDATA_OUT_W = ((MANT_W + SCALE_W + 7) / 8) * 8;
    localparam int TDATA_PAD_W = TDATA_OUT_W - MANT_W - SCALE_W;
    localparam int TUSER_OUT_W = 3;

    // wide enough to hold ten times the largest magnitude plus a digit
    localparam int PROD_W = MANT_W + 3;

    localparam logic [CHAR_W-1:0] CHR_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHR_POINT = 8'd46;
    localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHR_NINE  = 8'd57;

    localparam logic [MANT_W-1:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic                  too_long;
        logic                  overflowed;
        logic                  is_valid;
        logic [SCALE_W-1:0]    scale_digits;
        logic [MANT_W-1:0]     mantissa;
    } t_result;

endpackage

// ===== rtl/decimal_text_to_number_core.sv =====
// decimal text to number core: checks one text line and converts it to a scaled decimal
// depends on dtn_pkg for character codes, limits and the result layout

// One character of a text line enters per word on the slave side; tlast marks the
// last word of the line and tuser says whether tdata carries a character at all
// (tuser low with tlast high closes an empty line). A well formed line is an optional
// leading '+' or '-', then digits with at most one '.'. On the last word one result
// word leaves on the master side: value = mantissa / 10^scale_digits, with the
// mantissa saturated to +/-(2^63-1) and flagged in overflowed. Lines longer than
// MAX_LENGTH characters are reported invalid with too_long set; an invalid line
// gives mantissa and scale of zero. Throughput is one character per clock unless a line
// end meets a full, stalled output; a word passes the input register, then the result
// register. The multiply-by-ten, add and compare on the 64-bit accumulator set the cycle.
// A word with neither a character nor tlast changes nothing and gives no result.
module decimal_text_to_number_core
    import dtn_pkg::*;
#(
    parameter int MAX_LENGTH = 19
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [CHAR_W-1:0]       i_s_axis_tdata,   // [7:0] character
    input  logic                    i_s_axis_tuser,   // [0] has_character
    input  logic                    i_s_axis_tlast,   // end_of_line

    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [TDATA_OUT_W-1:0]  o_m_axis_tdata,   // [63:0] mantissa, [68:64] scale_digits
    output logic [TUSER_OUT_W-1:0]  o_m_axis_tuser    // [0] is_valid, [1] overflowed, [2] too_long
);

    localparam int POS_W = $clog2(MAX_LENGTH + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH);

    // input register
    logic                r_in_vld;
    logic [CHAR_W-1:0]   r_in_char;
    logic                r_in_has;
    logic                r_in_last;

    // line state
    logic [MANT_W-1:0]   r_acc,   n_acc;
    logic [SCALE_W-1:0]  r_frac,  n_frac;
    logic                r_point, n_point;
    logic                r_neg,   n_neg;
    logic [POS_W-1:0]    r_pos,   n_pos;
    logic                r_err,   n_err;
    logic                r_sat,   n_sat;
    logic                r_long,  n_long;

    // result register
    logic                r_out_vld;
    t_result             r_out,   n_out;

    logic                w_proc;
    logic                w_adv;
    logic [CHAR_W-1:0]   w_code;
    logic [DIGIT_W-1:0]  w_digit;
    logic                w_is_digit;
    logic [PROD_W-1:0]   w_next_mag;
    logic                w_over;
    logic                w_line_ok;

    // the stage works on its word unless a result would land on a full, stalled output
    assign w_adv  = r_in_vld && !(r_in_last && r_out_vld && !i_m_axis_tready);
    assign w_proc = w_adv;
    assign o_s_axis_tready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_char <= i_s_axis_tdata;
            r_in_has  <= i_s_axis_tuser;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // digit arithmetic: ten times the magnitude plus the digit, checked against the limit
    assign w_code     = r_in_char - CHR_ZERO;
    assign w_digit    = w_code[DIGIT_W-1:0];
    assign w_is_digit = (r_in_char >= CHR_ZERO) && (r_in_char <= CHR_NINE);
    assign w_next_mag = ({3'b000, r_acc} << 3) + ({3'b000, r_acc} << 1)
                      + PROD_W'(w_digit);
    assign w_over     = w_next_mag > PROD_W'(MAG_LIMIT);

    // next line state and result
    always_comb begin
        n_acc   = r_acc;
        n_frac  = r_frac;
        n_point = r_point;
        n_neg   = r_neg;
        n_pos   = r_pos;
        n_err   = r_err;
        n_sat   = r_sat;
        n_long  = r_long;

        if (r_in_has) begin
            if (r_pos >= POS_MAX) begin
                // past the length limit: flagged, not examined
                n_long = 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
                if (r_in_char == CHR_PLUS || r_in_char == CHR_MINUS) begin
                    if (r_pos != '0) begin
                        n_err = 1'b1;
                    end else if (r_in_char == CHR_MINUS) begin
                        n_neg = 1'b1;
                    end
                end else if (r_in_char == CHR_POINT) begin
                    if (r_point) begin
                        n_err = 1'b1;
                    end
                    n_point = 1'b1;
                end else if (w_is_digit) begin
                    if (!r_sat) begin
                        if (w_over) begin
                            n_acc = MAG_LIMIT;
                            n_sat = 1'b1;
                        end else begin
                            n_acc = w_next_mag[MANT_W-1:0];
                        end
                    end
                    if (r_point) begin
                        n_frac = r_frac + 1'b1;
                    end
                end else begin
                    n_err = 1'b1;
                end
            end
        end

        w_line_ok = !n_err && !n_long;
        n_out.is_valid     = w_line_ok;
        n_out.overflowed   = n_sat;
        n_out.too_long     = n_long;
        n_out.mantissa     = '0;
        n_out.scale_digits = '0;
        if (w_line_ok) begin
            n_out.mantissa     = n_neg ? (MANT_W'(0) - n_acc) : n_acc;
            n_out.scale_digits = n_frac;
        end

        // line end clears the line state for the next line
        if (r_in_last) begin
            n_acc   = '0;
            n_frac  = '0;
            n_point = 1'b0;
            n_neg   = 1'b0;
            n_pos   = '0;
            n_err   = 1'b0;
            n_sat   = 1'b0;
            n_long  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_frac  <= '0;
            r_point <= 1'b0;
            r_neg   <= 1'b0;
            r_pos   <= '0;
            r_err   <= 1'b0;
            r_sat   <= 1'b0;
            r_long  <= 1'b0;
        end else if (w_proc) begin
            r_acc   <= n_acc;
            r_frac  <= n_frac;
            r_point <= n_point;
            r_neg   <= n_neg;
            r_pos   <= n_pos;
            r_err   <= n_err;
            r_sat   <= n_sat;
            r_long  <= n_long;
        end
    end

    // result register: loads on a line end, drains when the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_proc && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in_last) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{TDATA_PAD_W{1'b0}}, r_out.scale_digits, r_out.mantissa};
    assign o_m_axis_tuser  = {r_out.too_long, r_out.overflowed, r_out.is_valid};

`ifndef ASSERT_OFF
    // character count never runs past the length limit
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("character position past limit");

    // a saturated accumulator sits exactly at the limit
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_acc == MAG_LIMIT))
        else $error("saturated accumulator off the limit");

    // magnitude never reaches the sign bit
    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_acc[MANT_W-1])
        else $error("accumulator above limit");

    // an invalid line reports zero mantissa and scale
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.is_valid) |-> (r_out.mantissa == '0 && r_out.scale_digits == '0))
        else $error("invalid line with nonzero value");

    // a processed line end leaves the line state cleared
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in_last) |=> (r_pos == '0 && !r_err && !r_long && r_acc == '0))
        else $error("line state not cleared");
`endif

endmodule
